### rtl/olqe_pkg.sv
// Package for the ordered list queue engine: operation and status codes,
// state machine encoding. No dependencies.
package olqe_pkg;

    localparam int OP_W = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE   = 3'd0,
        OP_DEQUEUE   = 3'd1,
        OP_SEARCH    = 3'd2,
        OP_INS_AFTER = 3'd3,
        OP_INS_BEFORE = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_EMIT,
        S_DONE
    } state_t;

endpackage

### rtl/ordered_list_queue_engine.sv
// Ordered list queue engine: circular linked list in a value and a link memory.
// The final result is set in S_DONE for all but a dequeue of a non-empty list,
// whose result is set in S_WALK_CHK after the head read; search and keyed insert
// first walk the list through S_WALK_RD and S_WALK_CHK, one list entry at a time
// through the single read port. One item at a time: the next input is taken only in S_IDLE.
// Reset: aresetn synchronous active low clears head, tail, count, control and marks all slots free.
module ordered_list_queue_engine #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: op [2:0], value [34:3], key [66:35], zero fill to 72 bits
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status [1:0], data [33:2], position [38:34], entries [43:39],
    // zero fill to 48 bits
    output logic [47:0] m_tdata,
    output logic        m_tlast
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // memories
    logic [olqe_pkg::DATA_W-1:0] value_mem [DEPTH];
    logic [AW-1:0]               link_mem  [DEPTH];
    logic [olqe_pkg::DATA_W-1:0] val_rd;
    logic [AW-1:0]               link_rd;

    olqe_pkg::state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [DEPTH-1:0] free_reg, free_next;
    logic [olqe_pkg::OP_W-1:0] op_reg, op_next;
    logic [olqe_pkg::DATA_W-1:0] value_reg, value_next, key_reg, key_next;
    logic [AW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          hit_any_reg, hit_any_next;
    // latest search hit, held back until the next hit or the end of the walk
    logic [4:0]    hit_pos_reg, hit_pos_next;
    // result pending output
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    o_status_reg, o_status_next;
    logic [olqe_pkg::DATA_W-1:0] o_data_reg, o_data_next;
    logic [4:0]    o_pos_reg, o_pos_next;
    logic          o_last_reg, o_last_next;

    // memory port controls
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          vw_en, lw_en, lw2_en;
    logic [AW-1:0] vw_addr, lw_addr, lw2_addr;
    logic [olqe_pkg::DATA_W-1:0] vw_data;
    logic [AW-1:0] lw_data, lw2_data;

    // lowest free slot
    logic [AW-1:0] free_slot;
    always_comb begin
        free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                free_slot = AW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (vw_en) begin
            value_mem[vw_addr] <= vw_data;
        end
        if (lw_en) begin
            link_mem[lw_addr] <= lw_data;
        end
        if (lw2_en) begin
            link_mem[lw2_addr] <= lw2_data;
        end
        if (rd_en) begin
            val_rd  <= value_mem[rd_addr];
            link_rd <= link_mem[rd_addr];
        end
    end

    wire [olqe_pkg::OP_W-1:0] in_op = s_tdata[2:0];
    wire out_busy = m_tvalid && !m_tready;
    wire is_full = (count_reg == CW'(DEPTH));

    assign s_tready = (state_reg == olqe_pkg::S_IDLE) && !out_busy;

    always_comb begin
        state_next = state_reg;
        head_next = head_reg; tail_next = tail_reg; count_next = count_reg;
        free_next = free_reg; op_next = op_reg; value_next = value_reg;
        key_next = key_reg; cur_next = cur_reg; prev_next = prev_reg;
        idx_next = idx_reg; hit_any_next = hit_any_reg;
        hit_pos_next = hit_pos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        o_status_next = o_status_reg; o_data_next = o_data_reg;
        o_pos_next = o_pos_reg; o_last_next = o_last_reg;
        rd_en = 1'b0; rd_addr = cur_reg;
        vw_en = 1'b0; vw_addr = free_slot; vw_data = value_reg;
        lw_en = 1'b0; lw_addr = free_slot; lw_data = '0;
        lw2_en = 1'b0; lw2_addr = tail_reg; lw2_data = '0;

        unique case (state_reg)
            olqe_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next = in_op;
                    value_next = s_tdata[34:3];
                    key_next = s_tdata[66:35];
                    cur_next = head_reg;
                    prev_next = head_reg;
                    idx_next = '0;
                    hit_any_next = 1'b0;
                    state_next = olqe_pkg::S_DONE;
                    if (in_op == olqe_pkg::OP_DEQUEUE && count_reg != '0) begin
                        rd_en = 1'b1;
                        rd_addr = head_reg;
                        state_next = olqe_pkg::S_WALK_CHK;
                    end else if ((in_op == olqe_pkg::OP_SEARCH
                                  || in_op == olqe_pkg::OP_INS_AFTER
                                  || in_op == olqe_pkg::OP_INS_BEFORE)
                                 && count_reg != '0 && !(is_full
                                 && in_op != olqe_pkg::OP_SEARCH)) begin
                        state_next = olqe_pkg::S_WALK_RD;
                    end
                end
            end
            olqe_pkg::S_WALK_RD: begin
                rd_en = 1'b1;
                rd_addr = cur_reg;
                state_next = olqe_pkg::S_WALK_CHK;
            end
            olqe_pkg::S_WALK_CHK: begin
                if (op_reg == olqe_pkg::OP_DEQUEUE) begin
                    count_next = count_reg - 1'b1;
                    free_next[head_reg] = 1'b1;
                    if (count_reg == CW'(1)) begin
                        head_next = '0; tail_next = '0;
                    end else begin
                        head_next = link_rd;
                        lw2_en = 1'b1; lw2_addr = tail_reg; lw2_data = link_rd;
                    end
                    out_valid_next = 1'b1;
                    o_status_next = olqe_pkg::ST_OK;
                    o_data_next = val_rd;
                    o_pos_next = '0;
                    o_last_next = 1'b1;
                    state_next = olqe_pkg::S_EMIT;
                end else if (op_reg == olqe_pkg::OP_SEARCH) begin
                    if (!out_busy) begin
                        if (val_rd == key_reg) begin
                            // release the held hit; it is not the last one
                            if (hit_any_reg) begin
                                out_valid_next = 1'b1;
                                o_status_next = olqe_pkg::ST_OK;
                                o_data_next = key_reg;
                                o_pos_next = hit_pos_reg;
                                o_last_next = 1'b0;
                            end
                            hit_any_next = 1'b1;
                            hit_pos_next = 5'(idx_reg + 1'b1);
                        end
                        idx_next = idx_reg + 1'b1;
                        cur_next = link_rd;
                        state_next = (idx_reg + 1'b1 == count_reg)
                            ? olqe_pkg::S_DONE : olqe_pkg::S_WALK_RD;
                    end
                end else begin
                    if (val_rd == key_reg) begin
                        hit_any_next = 1'b1;
                        vw_en = 1'b1;
                        free_next[free_slot] = 1'b0;
                        count_next = count_reg + 1'b1;
                        lw_en = 1'b1; lw_addr = free_slot;
                        if (op_reg == olqe_pkg::OP_INS_AFTER) begin
                            lw_data = link_rd;
                            lw2_en = 1'b1; lw2_addr = cur_reg; lw2_data = free_slot;
                            if (cur_reg == tail_reg) begin
                                tail_next = free_slot;
                            end
                        end else begin
                            lw_data = cur_reg;
                            lw2_en = 1'b1; lw2_data = free_slot;
                            if (idx_reg == '0) begin
                                head_next = free_slot;
                                lw2_addr = tail_reg;
                            end else begin
                                lw2_addr = prev_reg;
                            end
                        end
                        state_next = olqe_pkg::S_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        prev_next = cur_reg;
                        cur_next = link_rd;
                        state_next = (idx_reg + 1'b1 == count_reg)
                            ? olqe_pkg::S_DONE : olqe_pkg::S_WALK_RD;
                    end
                end
            end
            olqe_pkg::S_EMIT: begin
                if (!out_busy) begin
                    state_next = olqe_pkg::S_IDLE;
                end
            end
            olqe_pkg::S_DONE: begin
                // final result for everything but a dequeue of a non-empty list
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    o_data_next = '0;
                    o_pos_next = '0;
                    o_last_next = 1'b1;
                    o_status_next = olqe_pkg::ST_OK;
                    state_next = olqe_pkg::S_IDLE;
                    priority case (1'b1)
                        (op_reg == olqe_pkg::OP_ENQUEUE
                         || (op_reg == olqe_pkg::OP_INS_AFTER && count_reg == '0)): begin
                            if (is_full) begin
                                o_status_next = olqe_pkg::ST_FULL;
                            end else begin
                                vw_en = 1'b1;
                                free_next[free_slot] = 1'b0;
                                lw_en = 1'b1;
                                count_next = count_reg + 1'b1;
                                tail_next = free_slot;
                                if (count_reg == '0) begin
                                    head_next = free_slot;
                                    lw_data = free_slot;
                                end else begin
                                    lw_data = head_reg;
                                    lw2_en = 1'b1; lw2_addr = tail_reg;
                                    lw2_data = free_slot;
                                end
                            end
                        end
                        (op_reg == olqe_pkg::OP_DEQUEUE
                         || op_reg == olqe_pkg::OP_SEARCH
                         || op_reg == olqe_pkg::OP_INS_AFTER
                         || op_reg == olqe_pkg::OP_INS_BEFORE): begin
                            if (hit_any_reg) begin
                                // last search hit goes out here with the last flag
                                if (op_reg == olqe_pkg::OP_SEARCH) begin
                                    o_data_next = key_reg;
                                    o_pos_next = hit_pos_reg;
                                end
                            end else if (count_reg == '0) begin
                                o_status_next = olqe_pkg::ST_EMPTY;
                            end else if (is_full && op_reg != olqe_pkg::OP_SEARCH) begin
                                o_status_next = olqe_pkg::ST_FULL;
                            end else begin
                                o_status_next = olqe_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            // undefined op: drop without a result
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            default: state_next = olqe_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olqe_pkg::S_IDLE;
            head_reg <= '0; tail_reg <= '0; count_reg <= '0;
            free_reg <= '1;
            out_valid_reg <= 1'b0;
            hit_any_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg <= head_next; tail_reg <= tail_next; count_reg <= count_next;
            free_reg <= free_next;
            out_valid_reg <= out_valid_next;
            hit_any_reg <= hit_any_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; value_reg <= value_next; key_reg <= key_next;
        cur_reg <= cur_next; prev_reg <= prev_next; idx_reg <= idx_next;
        hit_pos_reg <= hit_pos_next;
        o_status_reg <= o_status_next; o_data_reg <= o_data_next;
        o_pos_reg <= o_pos_next; o_last_reg <= o_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {4'd0, 5'(count_reg), o_pos_reg, o_data_reg, o_status_reg};

endmodule
